// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication, checked on the rising edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// ===== rtl/i2ctrm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2ctrm_pkg
// shared types, codes and defaults of the i2c target register map
// ----------------------------------------------------------------------------
`default_nettype none

package i2ctrm_pkg;

	localparam int DEF_NUM_ENTRIES = 4;
	localparam int DEF_RX_BYTES    = 8;
	localparam int DEF_ENTRY_BYTES = 7;

	// entries that the address and size registers can describe
	localparam int DESCRIBED_ENTRIES = 4;
	localparam int SIZE_W            = 3;
	localparam int HOST_BYTES        = 7;
	localparam int HOST_W            = HOST_BYTES * 8;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 64;

	localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
	localparam logic [1:0] REG_ENTRY_ADDRS = 2'd1;
	localparam logic [1:0] REG_ENTRY_SIZES = 2'd2;

	localparam logic [2:0] CMD_MATCH = 3'd0;
	localparam logic [2:0] CMD_BYTE  = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_SET   = 3'd3;
	localparam logic [2:0] CMD_GET   = 3'd4;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_NO_ENTRY = 2'd1;
	localparam logic [1:0] STS_MISMATCH = 2'd2;
	localparam logic [1:0] STS_NOTHING  = 2'd3;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_MATCHED = 2'd1;
	localparam logic [1:0] PH_RECV    = 2'd2;
	localparam logic [1:0] PH_STOPPED = 2'd3;

	typedef struct packed {
		logic [2:0]  entry_count;
		logic [31:0] entry_addresses;
		logic [11:0] entry_sizes;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic find;
		logic exec;
	} ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/i2ctrm_cfg.sv =====
// ----------------------------------------------------------------------------
// i2ctrm_cfg
// apb configuration registers: entry count, addresses and sizes
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctrm_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [i2ctrm_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [i2ctrm_pkg::CFG_DATA_W-1:0]   pwdata,
	output      logic [i2ctrm_pkg::CFG_DATA_W-1:0]   prdata,
	output      logic                                pready,
	output      i2ctrm_pkg::cfg_t                    cfg
);

	i2ctrm_pkg::cfg_t cfg_q;
	logic             wr_en;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				i2ctrm_pkg::REG_ENTRY_COUNT: cfg_q.entry_count     <= pwdata[2:0];
				i2ctrm_pkg::REG_ENTRY_ADDRS: cfg_q.entry_addresses <= pwdata[31:0];
				i2ctrm_pkg::REG_ENTRY_SIZES: cfg_q.entry_sizes     <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			i2ctrm_pkg::REG_ENTRY_COUNT: prdata = {29'd0, cfg_q.entry_count};
			i2ctrm_pkg::REG_ENTRY_ADDRS: prdata = cfg_q.entry_addresses;
			i2ctrm_pkg::REG_ENTRY_SIZES: prdata = {20'd0, cfg_q.entry_sizes};
			default:                     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/i2ctrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2ctrm_ctrl
// sequencer: accept, entry lookup, execute, output handshake
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctrm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_ready,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      i2ctrm_pkg::ctrl_cmd_t ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	assign ctl.load = (state_q == ST_IDLE) && in_valid;
	assign ctl.find = (state_q == ST_FIND);
	assign ctl.exec = (state_q == ST_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EXEC) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/i2ctrm_dp.sv =====
// ----------------------------------------------------------------------------
// i2ctrm_dp
// datapath: item register, entry lookup, receive buffer, entry storage
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctrm_dp #(
	parameter int NUM_ENTRIES = i2ctrm_pkg::DEF_NUM_ENTRIES,
	parameter int RX_BYTES    = i2ctrm_pkg::DEF_RX_BYTES,
	parameter int ENTRY_BYTES = i2ctrm_pkg::DEF_ENTRY_BYTES
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire i2ctrm_pkg::ctrl_cmd_t            ctl,
	input  wire i2ctrm_pkg::cfg_t                 cfg,
	input  wire logic [2:0]                       cmd,
	input  wire logic [7:0]                       rx_byte,
	input  wire logic                             is_read,
	input  wire logic [7:0]                       reg_address,
	input  wire logic [2:0]                       host_length,
	input  wire logic [i2ctrm_pkg::HOST_W-1:0]    host_data,
	output      logic [1:0]                       status,
	output      logic [i2ctrm_pkg::HOST_W-1:0]    data_out,
	output      logic [2:0]                       length_out,
	output      logic [1:0]                       bus_state
);

	localparam int IdxW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int Lookup  = (NUM_ENTRIES < i2ctrm_pkg::DESCRIBED_ENTRIES) ?
		NUM_ENTRIES : i2ctrm_pkg::DESCRIBED_ENTRIES;
	localparam int CntW    = $clog2(RX_BYTES + 1);
	localparam int RxIdxW  = $clog2(RX_BYTES);
	localparam int CmpW    = (CntW > i2ctrm_pkg::SIZE_W) ? CntW : i2ctrm_pkg::SIZE_W;
	localparam int OutBytes = (ENTRY_BYTES < i2ctrm_pkg::HOST_BYTES) ?
		ENTRY_BYTES : i2ctrm_pkg::HOST_BYTES;
	localparam int MaxSizeI = (ENTRY_BYTES < 7) ? ENTRY_BYTES : 7;
	localparam logic [2:0] MaxSize = 3'(MaxSizeI);

	// item register
	logic [2:0]                    cmd_q;
	logic [7:0]                    rx_byte_q;
	logic                          is_read_q;
	logic [7:0]                    reg_addr_q;
	logic [2:0]                    hlen_q;
	logic [i2ctrm_pkg::HOST_W-1:0] hdata_q;

	// lookup result
	logic            hit_q;
	logic [IdxW-1:0] idx_q;
	logic [2:0]      size_q;

	// state
	logic [NUM_ENTRIES-1:0][ENTRY_BYTES-1:0][7:0] store_q;
	logic [RX_BYTES-1:0][7:0]                     rx_buf_q;
	logic [CntW-1:0]                              rx_cnt_q;
	logic [1:0]                                   phase_q;

	// output register
	logic [1:0]                    status_q;
	logic [i2ctrm_pkg::HOST_W-1:0] data_q;
	logic [2:0]                    len_q;

	logic [7:0]      look_addr;
	logic            hit_d;
	logic [IdxW-1:0] idx_d;
	logic [2:0]      size_d;
	logic [2:0]      raw_size;

	logic [1:0]                    status_d;
	logic [i2ctrm_pkg::HOST_W-1:0] data_d;
	logic [2:0]                    len_d;
	logic [1:0]                    phase_d;
	logic                          do_commit;
	logic                          do_set;

	logic [(RX_BYTES+ENTRY_BYTES)*8-1:0]           rx_ext;
	logic [i2ctrm_pkg::HOST_W+ENTRY_BYTES*8-1:0]   host_ext;

	assign rx_ext   = {{(ENTRY_BYTES*8){1'b0}}, rx_buf_q};
	assign host_ext = {{(ENTRY_BYTES*8){1'b0}}, hdata_q};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= cmd;
			rx_byte_q  <= rx_byte;
			is_read_q  <= is_read;
			reg_addr_q <= reg_address;
			hlen_q     <= host_length;
			hdata_q    <= host_data;
		end
	end

	// lowest matching entry wins
	always_comb begin
		look_addr = (cmd_q == i2ctrm_pkg::CMD_STOP) ? rx_buf_q[0] : reg_addr_q;
		hit_d     = 1'b0;
		idx_d     = '0;
		size_d    = '0;
		raw_size  = '0;
		for (int e = Lookup - 1; e >= 0; e--) begin
			if ((3'(e) < cfg.entry_count) && (cfg.entry_addresses[8*e +: 8] == look_addr)) begin
				hit_d    = 1'b1;
				idx_d    = IdxW'(e);
				raw_size = cfg.entry_sizes[3*e +: 3];
				size_d   = (raw_size > MaxSize) ? MaxSize : raw_size;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.find) begin
			hit_q  <= hit_d;
			idx_q  <= idx_d;
			size_q <= size_d;
		end
	end

	always_comb begin
		status_d  = i2ctrm_pkg::STS_OK;
		data_d    = '0;
		len_d     = '0;
		phase_d   = phase_q;
		do_commit = 1'b0;
		do_set    = 1'b0;
		case (cmd_q)
			i2ctrm_pkg::CMD_MATCH: begin
				phase_d = i2ctrm_pkg::PH_MATCHED;
			end
			i2ctrm_pkg::CMD_BYTE: begin
				phase_d = i2ctrm_pkg::PH_RECV;
			end
			i2ctrm_pkg::CMD_STOP: begin
				phase_d = i2ctrm_pkg::PH_STOPPED;
				if (is_read_q || (rx_cnt_q < CntW'(2))) begin
					status_d = i2ctrm_pkg::STS_NOTHING;
				end else if (!hit_q) begin
					status_d = i2ctrm_pkg::STS_NO_ENTRY;
				end else if (CmpW'(size_q) != (CmpW'(rx_cnt_q) - CmpW'(1))) begin
					status_d = i2ctrm_pkg::STS_MISMATCH;
				end else begin
					do_commit = 1'b1;
				end
			end
			i2ctrm_pkg::CMD_SET: begin
				if (!hit_q) begin
					status_d = i2ctrm_pkg::STS_NO_ENTRY;
				end else if (hlen_q > size_q) begin
					status_d = i2ctrm_pkg::STS_MISMATCH;
				end else begin
					do_set = 1'b1;
				end
			end
			i2ctrm_pkg::CMD_GET: begin
				if (!hit_q) begin
					status_d = i2ctrm_pkg::STS_NO_ENTRY;
				end else if (hlen_q < size_q) begin
					status_d = i2ctrm_pkg::STS_MISMATCH;
				end else begin
					len_d = size_q;
					for (int i = 0; i < OutBytes; i++) begin
						if (i < int'(size_q)) begin
							data_d[8*i +: 8] = store_q[idx_q][i];
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q  <= '0;
			rx_buf_q <= '0;
			rx_cnt_q <= '0;
			phase_q  <= i2ctrm_pkg::PH_IDLE;
		end else if (ctl.exec) begin
			phase_q <= phase_d;
			if (cmd_q == i2ctrm_pkg::CMD_MATCH) begin
				rx_buf_q <= '0;
				rx_cnt_q <= '0;
			end
			if ((cmd_q == i2ctrm_pkg::CMD_BYTE) && (rx_cnt_q < CntW'(RX_BYTES))) begin
				rx_buf_q[rx_cnt_q[RxIdxW-1:0]] <= rx_byte_q;
				rx_cnt_q <= rx_cnt_q + CntW'(1);
			end
			for (int i = 0; i < ENTRY_BYTES; i++) begin
				if (do_commit && (i < int'(size_q))) begin
					store_q[idx_q][i] <= rx_ext[8*(i+1) +: 8];
				end
				if (do_set && (i < int'(hlen_q))) begin
					store_q[idx_q][i] <= host_ext[8*i +: 8];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q <= status_d;
			data_q   <= data_d;
			len_q    <= len_d;
		end
	end

	assign status     = status_q;
	assign data_out   = data_q;
	assign length_out = len_q;
	assign bus_state  = phase_q;

endmodule

`default_nettype wire

// ===== rtl/i2c_target_register_map_top.sv =====
// ----------------------------------------------------------------------------
// i2c_target_register_map_top
// register map behind an i2c target: bus events, host set and get
// ----------------------------------------------------------------------------
// Each item gives exactly one result. It is first registered, then the
// entry lookup (a priority compare of the entry addresses) runs, and
// last the receive buffer or entry storage is updated and the output
// register loaded. The block accepts the next item while that result
// waits to be taken, and stalls in the update step only while the output
// register is still full. Storage and the receive buffer clear at reset.
`default_nettype none

module i2c_target_register_map_top #(
	parameter int NUM_ENTRIES = i2ctrm_pkg::DEF_NUM_ENTRIES,
	parameter int RX_BYTES    = i2ctrm_pkg::DEF_RX_BYTES,
	parameter int ENTRY_BYTES = i2ctrm_pkg::DEF_ENTRY_BYTES
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output      logic                                 s_axis_tready,
	// rx_byte, is_read, reg_address, host_length, host_data, zero pad
	input  wire logic [i2ctrm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// cmd
	input  wire logic [2:0]                           s_axis_tuser,
	output      logic                                 m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// status, data_out, length_out, bus_state, zero pad
	output      logic [i2ctrm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [i2ctrm_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [i2ctrm_pkg::CFG_DATA_W-1:0]    pwdata,
	output      logic [i2ctrm_pkg::CFG_DATA_W-1:0]    prdata,
	output      logic                                 pready
);

	i2ctrm_pkg::cfg_t      cfg;
	i2ctrm_pkg::ctrl_cmd_t ctl;

	logic [1:0]                    status;
	logic [i2ctrm_pkg::HOST_W-1:0] data_out;
	logic [2:0]                    length_out;
	logic [1:0]                    bus_state;

	i2ctrm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	i2ctrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctl       (ctl)
	);

	i2ctrm_dp #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.RX_BYTES    (RX_BYTES),
		.ENTRY_BYTES (ENTRY_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cfg         (cfg),
		.cmd         (s_axis_tuser),
		.rx_byte     (s_axis_tdata[7:0]),
		.is_read     (s_axis_tdata[8]),
		.reg_address (s_axis_tdata[16:9]),
		.host_length (s_axis_tdata[19:17]),
		.host_data   (s_axis_tdata[75:20]),
		.status      (status),
		.data_out    (data_out),
		.length_out  (length_out),
		.bus_state   (bus_state)
	);

	assign m_axis_tdata = {1'b0, bus_state, length_out, data_out, status};

endmodule

`default_nettype wire

// ===== rtl/i2ctrm_checker.sv =====
// ----------------------------------------------------------------------------
// i2ctrm_checker
// port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module i2ctrm_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               m_axis_tvalid,
	input wire logic                               m_axis_tready,
	input wire logic [i2ctrm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [1:0]                    status;
	logic [i2ctrm_pkg::HOST_W-1:0] data_out;
	logic [2:0]                    length_out;
	logic                          stalled;

	assign status     = m_axis_tdata[1:0];
	assign data_out   = m_axis_tdata[57:2];
	assign length_out = m_axis_tdata[60:58];
	assign stalled    = m_axis_tvalid && !m_axis_tready;

	`ASSERT_NEXT(a_valid_holds, clk, arst_n, stalled, m_axis_tvalid)
	`ASSERT_NEXT(a_data_holds, clk, arst_n, stalled, $stable(m_axis_tdata))
	`ASSERT_IMPLIES(a_len_only_ok, clk, arst_n, m_axis_tvalid && (length_out != 3'd0), status == i2ctrm_pkg::STS_OK)
	`ASSERT_IMPLIES(a_no_data_no_len, clk, arst_n, m_axis_tvalid && (length_out == 3'd0), data_out == '0)

endmodule

bind i2c_target_register_map_top i2ctrm_checker u_i2ctrm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
